@@ hdl/aru_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package aru_pkg;

  // sequencing position inside an event frame
  typedef enum logic [1:0] {
    PH_BLOCK  = 2'd0,
    PH_MODULE = 2'd1,
    PH_DATA   = 2'd2,
    PH_FILLER = 2'd3
  } frame_phase_t;

  // class of one result
  typedef enum logic [2:0] {
    WK_BLOCK_HDR  = 3'd0,
    WK_MODULE_HDR = 3'd1,
    WK_HIT        = 3'd2,
    WK_EXT_STAMP  = 3'd3,
    WK_END_EVENT  = 3'd4,
    WK_OTHER      = 3'd5,
    WK_BROKEN     = 3'd6,
    WK_HIST_READ  = 3'd7
  } word_kind_t;

  // histogram action carried to the back part
  typedef enum logic [1:0] {
    HOP_NONE = 2'd0,
    HOP_INC  = 2'd1,
    HOP_READ = 2'd2
  } hist_op_t;

  localparam logic [10:0] SIG_HIT       = 11'b00000100000;
  localparam logic [10:0] SIG_EXT_STAMP = 11'b00000100100;
  localparam logic [1:0]  EOE_MARK      = 2'b11;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  // one classified item, everything but the bin content
  typedef struct packed {
    word_kind_t  kind;
    logic [4:0]  hit_channel;
    logic [12:0] hit_value;
    logic [6:0]  hit_count;
    logic [15:0] extended_stamp;
    logic [29:0] event_stamp;
    logic [31:0] broken_events;
    logic        frame_end;
    hist_op_t    hop;
    logic [4:0]  hist_channel;
    logic [12:0] hist_bin;
  } item_rec_t;

endpackage

`default_nettype wire

@@ hdl/aru_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module aru_front #(
  parameter int unsigned NUM_CHANNELS = 32,
  parameter int unsigned NUM_BINS     = 8192,
  parameter int unsigned MAX_HITS     = 96
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire logic              operation,
  input  wire logic [31:0]       data_word,
  input  wire logic [4:0]        query_channel,
  input  wire logic [12:0]       query_bin,
  output aru_pkg::item_rec_t     rec
);

  localparam logic [5:0]  CH_LIMIT  = 6'(NUM_CHANNELS);
  localparam logic [13:0] BIN_LIMIT = 14'(NUM_BINS);
  localparam logic [6:0]  HIT_SAT   = 7'(MAX_HITS - 1);

  aru_pkg::frame_phase_t phase_r, phase_nxt;
  logic [12:0] words_left_r, words_left_nxt;
  logic [6:0]  hits_r, hits_nxt;
  logic [15:0] ext_r, ext_nxt;
  logic [29:0] evt_r, evt_nxt;
  logic [31:0] broken_r, broken_nxt;

  logic [12:0] len;
  logic [12:0] wl_dec;
  logic [10:0] sig;
  logic [4:0]  w_ch;
  logic [12:0] w_val;
  logic        hit_in_range;
  logic        query_in_range;

  assign len    = data_word[12:0];
  assign sig    = data_word[31:21];
  assign w_ch   = data_word[20:16];
  assign w_val  = data_word[12:0];
  assign wl_dec = (words_left_r != 13'd0) ? words_left_r - 13'd1 : words_left_r;

  assign hit_in_range   = ({1'b0, w_ch} < CH_LIMIT) && ({1'b0, w_val} < BIN_LIMIT);
  assign query_in_range = ({1'b0, query_channel} < CH_LIMIT)
                       && ({1'b0, query_bin} < BIN_LIMIT);

  // next state
  always_comb begin
    phase_nxt = phase_r;
    if (!operation) begin
      unique case (phase_r)
        aru_pkg::PH_BLOCK: begin
          if (len > 13'd1) begin
            phase_nxt = aru_pkg::PH_MODULE;
          end else if (len == 13'd1) begin
            phase_nxt = aru_pkg::PH_FILLER;
          end else begin
            phase_nxt = aru_pkg::PH_BLOCK;
          end
        end
        aru_pkg::PH_MODULE: phase_nxt = aru_pkg::PH_DATA;
        aru_pkg::PH_FILLER: phase_nxt = aru_pkg::PH_BLOCK;
        aru_pkg::PH_DATA: begin
          phase_nxt = (wl_dec == 13'd0) ? aru_pkg::PH_BLOCK : aru_pkg::PH_DATA;
        end
        default: phase_nxt = aru_pkg::PH_BLOCK;
      endcase
    end
  end

  // outputs and event registers
  always_comb begin
    words_left_nxt = words_left_r;
    hits_nxt       = hits_r;
    ext_nxt        = ext_r;
    evt_nxt        = evt_r;
    broken_nxt     = broken_r;
    rec              = '0;
    rec.kind         = aru_pkg::WK_OTHER;
    rec.hop          = aru_pkg::HOP_NONE;
    if (operation) begin
      rec.kind         = aru_pkg::WK_HIST_READ;
      rec.hist_channel = query_channel;
      rec.hist_bin     = query_bin;
      if (query_in_range) begin
        rec.hop = aru_pkg::HOP_READ;
      end
    end else begin
      unique case (phase_r)
        aru_pkg::PH_BLOCK: begin
          rec.kind = aru_pkg::WK_BLOCK_HDR;
          hits_nxt = '0;
          ext_nxt  = '0;
          evt_nxt  = '0;
          if (len > 13'd1) begin
            words_left_nxt = len - 13'd1;
          end else if (len == 13'd0) begin
            rec.frame_end = 1'b1;
          end
        end
        aru_pkg::PH_MODULE: rec.kind = aru_pkg::WK_MODULE_HDR;
        aru_pkg::PH_FILLER: begin
          rec.kind      = aru_pkg::WK_BROKEN;
          broken_nxt    = broken_r + 32'd1;
          rec.frame_end = 1'b1;
        end
        aru_pkg::PH_DATA: begin
          words_left_nxt = wl_dec;
          rec.frame_end  = (wl_dec == 13'd0);
          if (sig == aru_pkg::SIG_HIT) begin
            rec.kind         = aru_pkg::WK_HIT;
            rec.hit_channel  = w_ch;
            rec.hit_value    = w_val;
            rec.hist_channel = w_ch;
            rec.hist_bin     = w_val;
            hits_nxt         = (hits_r >= HIT_SAT) ? HIT_SAT : hits_r + 7'd1;
            if (hit_in_range) begin
              rec.hop = aru_pkg::HOP_INC;
            end
          end else if (sig == aru_pkg::SIG_EXT_STAMP) begin
            rec.kind = aru_pkg::WK_EXT_STAMP;
            ext_nxt  = data_word[15:0];
          end else if (data_word[31:30] == aru_pkg::EOE_MARK) begin
            rec.kind = aru_pkg::WK_END_EVENT;
            evt_nxt  = data_word[29:0];
          end
        end
        default: rec.kind = aru_pkg::WK_OTHER;
      endcase
    end
    rec.hit_count      = hits_nxt;
    rec.extended_stamp = ext_nxt;
    rec.event_stamp    = evt_nxt;
    rec.broken_events  = broken_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= aru_pkg::PH_BLOCK;
      words_left_r <= '0;
      hits_r       <= '0;
      ext_r        <= '0;
      evt_r        <= '0;
      broken_r     <= '0;
    end else if (accept) begin
      phase_r      <= phase_nxt;
      words_left_r <= words_left_nxt;
      hits_r       <= hits_nxt;
      ext_r        <= ext_nxt;
      evt_r        <= evt_nxt;
      broken_r     <= broken_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/aru_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module aru_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire aru_pkg::item_rec_t push_rec,
  input  wire logic               pop,
  output aru_pkg::item_rec_t      head_rec,
  output logic                    not_empty,
  output logic                    full
);

  aru_pkg::item_rec_t slot_r [aru_pkg::QUEUE_DEPTH];
  logic [aru_pkg::QPTR_W-1:0] wr_ptr_r;
  logic [aru_pkg::QPTR_W-1:0] rd_ptr_r;
  logic [aru_pkg::QCNT_W-1:0] count_r;

  assign head_rec  = slot_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign full      = (count_r == aru_pkg::QCNT_W'(aru_pkg::QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + aru_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + aru_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + aru_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - aru_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/aru_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module aru_back #(
  parameter int unsigned NUM_CHANNELS = 32,
  parameter int unsigned NUM_BINS     = 8192
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire aru_pkg::item_rec_t head_rec,
  input  wire logic              head_valid,
  output logic                   pop,
  output logic                   clearing,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output aru_pkg::item_rec_t     out_rec,
  output logic [31:0]            out_bin_count
);

  localparam int unsigned BIN_W     = $clog2(NUM_BINS);
  localparam int unsigned CH_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned ADDR_W    = CH_W + BIN_W;
  localparam int unsigned MEM_DEPTH = NUM_CHANNELS * (2 ** BIN_W);

  logic [31:0] hist_mem [MEM_DEPTH];

  logic               clear_active_r;
  logic [ADDR_W-1:0]  clear_addr_r;

  logic               s2_valid_r;
  aru_pkg::item_rec_t s2_rec_r;
  logic [31:0]        rd_data_r;

  logic               lw_valid_r;
  logic [ADDR_W-1:0]  lw_addr_r;
  logic [31:0]        lw_data_r;

  logic               out_valid_r;
  aru_pkg::item_rec_t out_rec_r;
  logic [31:0]        out_bin_r;

  logic               s2_adv;
  logic               s2_ready;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ADDR_W-1:0]  s2_addr;
  logic [31:0]        cur_bin;
  logic               we;
  logic [ADDR_W-1:0]  wa;
  logic [31:0]        wd;

  assign rd_addr = {head_rec.hist_channel[CH_W-1:0], head_rec.hist_bin[BIN_W-1:0]};
  assign s2_addr = {s2_rec_r.hist_channel[CH_W-1:0], s2_rec_r.hist_bin[BIN_W-1:0]};

  assign s2_adv   = s2_valid_r && (!out_valid_r || !out_stall);
  assign s2_ready = !s2_valid_r || s2_adv;
  assign pop      = head_valid && s2_ready && !clear_active_r;
  assign clearing = clear_active_r;

  // the write of the previous stage-2 item lands on the same edge as the read
  assign cur_bin = (lw_valid_r && (lw_addr_r == s2_addr)) ? lw_data_r : rd_data_r;

  always_comb begin
    we = 1'b0;
    wa = s2_addr;
    wd = cur_bin + 32'd1;
    if (clear_active_r) begin
      we = 1'b1;
      wa = clear_addr_r;
      wd = '0;
    end else if (s2_adv && (s2_rec_r.hop == aru_pkg::HOP_INC)) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      hist_mem[wa] <= wd;
    end
    if (pop) begin
      rd_data_r <= hist_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_active_r <= 1'b1;
      clear_addr_r   <= '0;
    end else if (clear_active_r) begin
      clear_addr_r <= clear_addr_r + ADDR_W'(1);
      if (clear_addr_r == ADDR_W'(MEM_DEPTH - 1)) begin
        clear_active_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_valid_r <= 1'b0;
    end else if (we) begin
      lw_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      lw_addr_r <= wa;
      lw_data_r <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s2_ready) begin
        s2_valid_r <= pop;
      end
      if (!out_valid_r || !out_stall) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s2_rec_r <= head_rec;
    end
    if (s2_adv) begin
      out_rec_r <= s2_rec_r;
      out_bin_r <= (s2_rec_r.hop == aru_pkg::HOP_READ) ? cur_bin : 32'd0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_rec       = out_rec_r;
  assign out_bin_count = out_bin_r;

endmodule

`default_nettype wire

@@ hdl/adc_readout_word_unpacker.sv @@
// adc event frame unpacker with per-channel histogram
//
// input channel (in_*): one item per transfer, either a 32-bit readout word
// (in_operation = 0) or a histogram bin query (in_operation = 1)
// result channel (out_*): exactly one result per input item, in order
// both channels use valid/stall; a transfer happens when valid is high and
// stall is low
//
// each item passes the queue, the internal stage and the output register
// throughput: one item per cycle unless stalled or clearing; the histogram
// read-modify-write is pipelined on the single port, last write forwarded
//
// reset: frame state and counters clear at once, then the histogram memory
// is cleared one bin per cycle, all NUM_CHANNELS * 2**clog2(NUM_BINS) bins
// (262144 at defaults); in_stall stays high during that pass
// receiver stall: the output register holds, the internal stage and the
// four-entry queue absorb items, then in_stall rises once the queue is full
`timescale 1ns / 1ps
`default_nettype none

module adc_readout_word_unpacker #(
  parameter int unsigned NUM_CHANNELS = 32,
  parameter int unsigned NUM_BINS     = 8192,
  parameter int unsigned MAX_HITS     = 96
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_operation,
  input  wire logic [31:0] in_data_word,
  input  wire logic [4:0]  in_query_channel,
  input  wire logic [12:0] in_query_bin,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_word_kind,
  output logic [4:0]       out_hit_channel,
  output logic [12:0]      out_hit_value,
  output logic [6:0]       out_hit_count,
  output logic [15:0]      out_extended_stamp,
  output logic [29:0]      out_event_stamp,
  output logic [31:0]      out_broken_events,
  output logic [31:0]      out_bin_count,
  output logic             out_frame_end
);

  aru_pkg::item_rec_t front_rec;
  aru_pkg::item_rec_t head_rec;
  aru_pkg::item_rec_t res_rec;

  logic in_xfer;
  logic q_not_empty;
  logic q_full;
  logic q_pop;
  logic clearing;

  // no new items while the queue is full or the histogram is being cleared
  assign in_stall = q_full || clearing;
  assign in_xfer  = in_valid && !in_stall;

  // frame parser and event registers
  aru_front #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .NUM_BINS     (NUM_BINS),
    .MAX_HITS     (MAX_HITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (in_xfer),
    .operation     (in_operation),
    .data_word     (in_data_word),
    .query_channel (in_query_channel),
    .query_bin     (in_query_bin),
    .rec           (front_rec)
  );

  // decouples the parser from the histogram pipeline
  aru_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_xfer),
    .push_rec  (front_rec),
    .pop       (q_pop),
    .head_rec  (head_rec),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  // histogram memory, bin update/read and output register
  aru_back #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .NUM_BINS     (NUM_BINS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_rec      (head_rec),
    .head_valid    (q_not_empty),
    .pop           (q_pop),
    .clearing      (clearing),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_rec       (res_rec),
    .out_bin_count (out_bin_count)
  );

  assign out_word_kind      = res_rec.kind;
  assign out_hit_channel    = res_rec.hit_channel;
  assign out_hit_value      = res_rec.hit_value;
  assign out_hit_count      = res_rec.hit_count;
  assign out_extended_stamp = res_rec.extended_stamp;
  assign out_event_stamp    = res_rec.event_stamp;
  assign out_broken_events  = res_rec.broken_events;
  assign out_frame_end      = res_rec.frame_end;

endmodule

`default_nettype wire

@@ tb/sv/aru_frame_checker.sv @@
`timescale 1ns / 1ps

package aru_tb_pkg;
  // in_operation codes
  localparam logic OP_WORD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;
endpackage

module aru_frame_checker #(
  parameter int unsigned NUM_CHANNELS = 32,
  parameter int unsigned NUM_BINS     = 8192,
  parameter int unsigned MAX_HITS     = 96
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_operation,
  input  logic [31:0] in_data_word,
  input  logic [4:0]  in_query_channel,
  input  logic [12:0] in_query_bin,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_word_kind,
  input  logic [4:0]  out_hit_channel,
  input  logic [12:0] out_hit_value,
  input  logic [6:0]  out_hit_count,
  input  logic [15:0] out_extended_stamp,
  input  logic [29:0] out_event_stamp,
  input  logic [31:0] out_broken_events,
  input  logic [31:0] out_bin_count,
  input  logic        out_frame_end,
  output int          mismatch_count,
  output int          words_in_flight,
  output logic        frame_idle
);
  import aru_pkg::*;
  import aru_tb_pkg::*;

  typedef struct packed {
    word_kind_t  kind;
    logic [4:0]  hit_channel;
    logic [12:0] hit_value;
    logic [6:0]  hit_count;
    logic [15:0] extended_stamp;
    logic [29:0] event_stamp;
    logic [31:0] broken_events;
    logic [31:0] bin_count;
    logic        frame_end;
  } unpacked_word_t;

  // mirror of the frame parser
  frame_phase_t phase;
  logic [12:0]  words_left;
  logic [6:0]   hits;
  logic [15:0]  ext_stamp;
  logic [29:0]  eoe_stamp;
  logic [31:0]  broken;
  bit   [31:0]  bin_store [NUM_CHANNELS * NUM_BINS];

  unpacked_word_t unpacked_q[$];

  function automatic unpacked_word_t unpack_item(logic op, logic [31:0] w, logic [4:0] qch,
                                                 logic [12:0] qbin);
    unpacked_word_t r;
    logic [12:0]    len;
    logic [10:0]    sig;
    int unsigned    idx;
    r = '0;
    if (op == OP_QUERY) begin
      r.kind = WK_HIST_READ;
      if (qch < NUM_CHANNELS && qbin < NUM_BINS)
        r.bin_count = bin_store[qch * NUM_BINS + qbin];
    end else begin
      case (phase)
        PH_BLOCK: begin
          len = w[12:0];
          r.kind = WK_BLOCK_HDR;
          hits = '0;
          ext_stamp = '0;
          eoe_stamp = '0;
          if (len > 13'd1) begin
            words_left = len - 13'd1;
            phase = PH_MODULE;
          end else if (len == 13'd1) begin
            phase = PH_FILLER;
          end else begin
            r.frame_end = 1'b1;
          end
        end
        PH_MODULE: begin
          r.kind = WK_MODULE_HDR;
          phase = PH_DATA;
        end
        PH_FILLER: begin
          r.kind = WK_BROKEN;
          broken = broken + 32'd1;
          phase = PH_BLOCK;
          r.frame_end = 1'b1;
        end
        default: begin
          sig = w[31:21];
          if (sig == SIG_HIT) begin
            r.kind = WK_HIT;
            r.hit_channel = w[20:16];
            r.hit_value = w[12:0];
            if (hits < MAX_HITS - 1) hits = hits + 7'd1;
            if (w[20:16] < NUM_CHANNELS && w[12:0] < NUM_BINS) begin
              idx = w[20:16] * NUM_BINS + w[12:0];
              bin_store[idx] = bin_store[idx] + 32'd1;
            end
          end else if (sig == SIG_EXT_STAMP) begin
            r.kind = WK_EXT_STAMP;
            ext_stamp = w[15:0];
          end else if (w[31:30] == EOE_MARK) begin
            r.kind = WK_END_EVENT;
            eoe_stamp = w[29:0];
          end else begin
            r.kind = WK_OTHER;
          end
          if (words_left != 13'd0) words_left = words_left - 13'd1;
          if (words_left == 13'd0) begin
            phase = PH_BLOCK;
            r.frame_end = 1'b1;
          end
        end
      endcase
    end
    r.hit_count = hits;
    r.extended_stamp = ext_stamp;
    r.event_stamp = eoe_stamp;
    r.broken_events = broken;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      // keep the log short on a badly broken block
      if (mismatch_count < 200)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    unpacked_word_t want;
    if (!rst_n) begin
      phase = PH_BLOCK;
      words_left = '0;
      hits = '0;
      ext_stamp = '0;
      eoe_stamp = '0;
      broken = '0;
      foreach (bin_store[i]) bin_store[i] = '0;
      unpacked_q.delete();
      mismatch_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (unpacked_q.size() == 0) begin
          $display("%0t: result with nothing outstanding, kind %0d", $time, out_word_kind);
          mismatch_count++;
        end else begin
          want = unpacked_q.pop_front();
          check_field("word_kind", 32'(want.kind), 32'(out_word_kind));
          check_field("hit_channel", 32'(want.hit_channel), 32'(out_hit_channel));
          check_field("hit_value", 32'(want.hit_value), 32'(out_hit_value));
          check_field("hit_count", 32'(want.hit_count), 32'(out_hit_count));
          check_field("extended_stamp", 32'(want.extended_stamp), 32'(out_extended_stamp));
          check_field("event_stamp", 32'(want.event_stamp), 32'(out_event_stamp));
          check_field("broken_events", want.broken_events, out_broken_events);
          check_field("bin_count", want.bin_count, out_bin_count);
          check_field("frame_end", 32'(want.frame_end), 32'(out_frame_end));
        end
      end
      if (in_valid && !in_stall)
        unpacked_q.push_back(unpack_item(in_operation, in_data_word, in_query_channel,
                                         in_query_bin));
    end
    words_in_flight = unpacked_q.size();
    frame_idle = (phase == PH_BLOCK);
  end

endmodule

@@ tb/sv/tb_adc_readout_word_unpacker.sv @@
`timescale 1ns / 1ps

module tb_adc_readout_word_unpacker;
  import aru_pkg::*;
  import aru_tb_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n;

  logic        in_valid;
  logic        in_stall;
  logic        in_operation;
  logic [31:0] in_data_word;
  logic [4:0]  in_query_channel;
  logic [12:0] in_query_bin;

  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_word_kind;
  logic [4:0]  out_hit_channel;
  logic [12:0] out_hit_value;
  logic [6:0]  out_hit_count;
  logic [15:0] out_extended_stamp;
  logic [29:0] out_event_stamp;
  logic [31:0] out_broken_events;
  logic [31:0] out_bin_count;
  logic        out_frame_end;

  int          mismatch_count;
  int          words_in_flight;
  logic        frame_idle;

  // no random idling on either side while calm is set
  bit          calm = 1'b0;
  int          items_sent = 0;
  // recently hit (channel, value) pairs, so that queries find filled bins
  logic [17:0] hot_bins[$];

  adc_readout_word_unpacker DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_data_word       (in_data_word),
    .in_query_channel   (in_query_channel),
    .in_query_bin       (in_query_bin),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_word_kind      (out_word_kind),
    .out_hit_channel    (out_hit_channel),
    .out_hit_value      (out_hit_value),
    .out_hit_count      (out_hit_count),
    .out_extended_stamp (out_extended_stamp),
    .out_event_stamp    (out_event_stamp),
    .out_broken_events  (out_broken_events),
    .out_bin_count      (out_bin_count),
    .out_frame_end      (out_frame_end)
  );

  aru_frame_checker frame_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_data_word       (in_data_word),
    .in_query_channel   (in_query_channel),
    .in_query_bin       (in_query_bin),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_word_kind      (out_word_kind),
    .out_hit_channel    (out_hit_channel),
    .out_hit_value      (out_hit_value),
    .out_hit_count      (out_hit_count),
    .out_extended_stamp (out_extended_stamp),
    .out_event_stamp    (out_event_stamp),
    .out_broken_events  (out_broken_events),
    .out_bin_count      (out_bin_count),
    .out_frame_end      (out_frame_end),
    .mismatch_count     (mismatch_count),
    .words_in_flight    (words_in_flight),
    .frame_idle         (frame_idle)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver side: random stall, changed at the falling edge
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 27);
  end

  // hard stop for a hung run, placed well past the reset clearing pass
  // of the histogram
  initial begin
    #12_000_000;
    $display("Verification failed");
    $finish;
  end

  // hit word with random don't-care bits 15:13
  function automatic logic [31:0] hit_word(logic [4:0] ch, logic [12:0] val);
    logic [2:0] pad;
    pad = 3'($urandom());
    hot_bins.push_back({ch, val});
    if (hot_bins.size() > 16) void'(hot_bins.pop_front());
    return {SIG_HIT, ch, pad, val};
  endfunction

  // one readout word of the given class; len only matters for a block header
  function automatic logic [31:0] make_word(word_kind_t kind, logic [12:0] len);
    logic [31:0] w;
    logic [4:0]  ch;
    logic [12:0] val;
    int unsigned r;
    w = $urandom();
    case (kind)
      WK_BLOCK_HDR: w[12:0] = len;
      WK_HIT: begin
        ch = ($urandom_range(0, 1) == 0) ? 5'($urandom_range(0, 3)) : 5'($urandom());
        r = $urandom_range(0, 99);
        // small values half the time so bins climb past one
        if (r < 50) val = 13'($urandom_range(0, 7));
        else if (r < 60) val = 13'h1fff;
        else val = 13'($urandom());
        w = hit_word(ch, val);
      end
      WK_EXT_STAMP: w[31:21] = SIG_EXT_STAMP;
      WK_END_EVENT: w[31:30] = EOE_MARK;
      WK_OTHER: begin
        while (w[31:21] == SIG_HIT || w[31:21] == SIG_EXT_STAMP || w[31:30] == EOE_MARK)
          w = $urandom();
      end
      default: ;
    endcase
    return w;
  endfunction

  // entered and left at a falling edge; the payload holds until the transfer
  task automatic send_item(logic op, logic [31:0] word, logic [4:0] qch, logic [12:0] qbin);
    while (!calm && $urandom_range(0, 99) < 27) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_data_word <= word;
    in_query_channel <= qch;
    in_query_bin <= qbin;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_word(logic [31:0] word);
    send_item(OP_WORD, word, 5'($urandom()), 13'($urandom()));
  endtask

  // bin query: mostly a recently hit bin, sometimes a corner or a random one
  task automatic send_query();
    logic [17:0] pick;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60 && hot_bins.size() != 0)
      pick = hot_bins[$urandom_range(0, hot_bins.size() - 1)];
    else if (r < 70)
      pick = {($urandom_range(0, 1) != 0) ? 5'd31 : 5'd0,
              ($urandom_range(0, 1) != 0) ? 13'h1fff : 13'd0};
    else
      pick = 18'($urandom());
    send_item(OP_QUERY, $urandom(), pick[17:13], pick[12:0]);
  endtask

  // sender holds off until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (words_in_flight != 0);
  endtask

  // one frame; a cut frame stops early and the parser is brought back to a block
  // header with plain data words
  task automatic send_frame(int unsigned len, int unsigned hit_pct, bit cut);
    int unsigned n;
    int unsigned r;
    word_kind_t  kind;
    send_word(make_word(WK_BLOCK_HDR, 13'(len)));
    if (len == 1) begin
      send_word(make_word(WK_BROKEN, '0));
    end else if (len > 1) begin
      send_word(make_word(WK_MODULE_HDR, '0));
      n = cut ? $urandom_range(0, len - 2) : len - 1;
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 99) < 12) send_query();
        r = $urandom_range(0, 99);
        if (r < hit_pct) kind = WK_HIT;
        else if (r % 3 == 0) kind = WK_EXT_STAMP;
        else if (r % 3 == 1) kind = WK_END_EVENT;
        else kind = WK_OTHER;
        send_word(make_word(kind, '0));
      end
    end
    while (!frame_idle) send_word(make_word(WK_OTHER, '0));
    if ($urandom_range(0, 99) < 12) send_query();
  endtask

  initial begin
    int unsigned frame_no;
    int unsigned r;
    int unsigned len;
    frame_no = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = OP_WORD;
    in_data_word = '0;
    in_query_channel = '0;
    in_query_bin = '0;
    out_stall = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // the first transfer waits out the histogram clearing pass behind in_stall
    @(negedge clk);

    // directed: empty bins at both corners
    send_item(OP_QUERY, 32'hffff_ffff, 5'd31, 13'h1fff);
    send_item(OP_QUERY, 32'h0000_0000, 5'd0, 13'd0);
    // zero-length frame, upper bits set
    send_word(32'hffff_e000);
    // broken frame: length one and its filler
    send_word(32'h0000_0001);
    send_word(32'hffff_ffff);
    // length six: module header and one word of every data class, extremes
    send_word(32'h0000_0006);
    send_word(32'h0000_0000);
    send_word(hit_word(5'd0, 13'd0));
    send_word(hit_word(5'd31, 13'h1fff));
    send_word({SIG_EXT_STAMP, 5'h1f, 16'hffff});
    send_word({EOE_MARK, 30'h3fff_ffff});
    send_word(32'h0000_0000);
    send_item(OP_QUERY, 32'h0, 5'd0, 13'd0);
    send_item(OP_QUERY, 32'h0, 5'd31, 13'h1fff);
    // back-to-back hit and query of the same bin, exercises write forwarding
    send_word({19'h7ffff, 13'd3});
    send_word(32'hffff_ffff);
    send_word(hit_word(5'd7, 13'd7));
    send_item(OP_QUERY, 32'h0, 5'd7, 13'd7);
    send_word(hit_word(5'd7, 13'd7));
    send_item(OP_QUERY, 32'h0, 5'd7, 13'd7);
    // new header clears the stamps of the previous event
    send_word({19'h0, 13'd2});
    send_word(32'h5555_aaaa);
    send_word({EOE_MARK, 30'h0});
    send_word({19'h2aaaa, 13'd0});
    drain();

    // random frames: mostly short well-formed ones, some broken or cut,
    // and a few long hit-heavy ones that saturate the multiplicity
    while (items_sent < 1175) begin
      frame_no++;
      calm = (frame_no >= 15 && frame_no < 28);
      if (frame_no % 25 == 0) drain();
      r = $urandom_range(0, 99);
      if (r < 10) len = 0;
      else if (r < 20) len = 1;
      else if (r < 26) len = $urandom_range(110, 300);
      else len = $urandom_range(2, 12);
      send_frame(len, (len >= 110) ? 90 : 40, $urandom_range(0, 99) < 8);
    end
    calm = 1'b0;

    drain();
    repeat (20) @(negedge clk);
    if (mismatch_count == 0 && words_in_flight == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
